FILE: design/gelu_activation_unit_assert.svh
// Assertion macros used by the checker of the GELU activation unit.
`ifndef GELU_ACTIVATION_UNIT_ASSERT_SVH
`define GELU_ACTIVATION_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GELU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gelu_activation_unit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent ends.
`define GELU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gelu_activation_unit: next-cycle check failed");

`endif

FILE: design/gelu_pkg.sv
package gelu_pkg;

    localparam int X_W               = 16;
    localparam int GQ                = 28;
    localparam int ENTRY_W           = GQ + 1;
    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int FRAC_BITS_DEF     = 12;

    localparam longint ONE_Q       = longint'(1) <<< GQ;
    localparam longint EINV_Q      = 98751886;
    localparam longint BETA2_Q     = 428361012;
    localparam longint KAPPA_Q     = 12003091;
    localparam longint INV_SQRT2_Q = 189812531;
    localparam longint AS_P        = 87937066;
    localparam longint AS_A1       = 68405298;
    localparam longint AS_A2       = -76369011;
    localparam longint AS_A3       = 381557846;
    localparam longint AS_A4       = -390077527;
    localparam longint AS_A5       = 284918850;

    // Shift-and-subtract quotient for a non-negative numerator and a positive divisor.
    function automatic longint div_pos(longint num, longint den);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int b = 62; b >= 0; b--)
        begin
            r = (r <<< 1) | ((num >>> b) & longint'(1));
            if (r >= den)
            begin
                r = r - den;
                q = q | (longint'(1) <<< b);
            end
        end
        return q;
    endfunction

    // Quotient truncated toward zero for a positive divisor.
    function automatic longint div_trunc(longint num, longint den);
        longint q;
        if (num < 0)
            q = -div_pos(-num, den);
        else
            q = div_pos(num, den);
        return q;
    endfunction

    function automatic longint mulq(longint a, longint b);
        return (a * b) / ONE_Q;
    endfunction

    // exp(-s) in Q.28 for s >= 0.
    function automatic longint exp_neg(longint s);
        longint sum;
        longint term;
        longint f;
        longint n;
        sum  = ONE_Q;
        term = ONE_Q;
        if (s >= 32 * ONE_Q)
            return 0;
        n = s / ONE_Q;
        f = s - n * ONE_Q;
        for (int i = 1; i <= 12; i++)
        begin
            term = div_pos((term * f) / ONE_Q, longint'(i));
            if ((i & 1) != 0)
                sum = sum - term;
            else
                sum = sum + term;
        end
        for (int i = 0; i < 32; i++)
        begin
            if (longint'(i) < n)
                sum = (sum * EINV_Q + ONE_Q / 2) / ONE_Q;
        end
        return sum;
    endfunction

    function automatic longint g_tanh(longint a);
        longint a2;
        longint a3;
        longint inner;
        longint s;
        longint d;
        if (a >= 8 * ONE_Q)
            return ONE_Q;
        a2    = (a * a) / ONE_Q;
        a3    = (a2 * (a / 256)) >>> 20;
        inner = a + (a3 * KAPPA_Q) / ONE_Q;
        s     = (inner * BETA2_Q) / ONE_Q;
        d     = ONE_Q + exp_neg(s);
        return div_pos(ONE_Q * ONE_Q + d / 2, d);
    endfunction

    function automatic longint g_erf(longint a);
        longint z;
        longint d;
        longint t;
        longint poly;
        longint h;
        if (a >= 8 * ONE_Q)
            return ONE_Q;
        z    = (a * INV_SQRT2_Q) / ONE_Q;
        d    = ONE_Q + (z * AS_P) / ONE_Q;
        t    = div_pos(ONE_Q * ONE_Q + d / 2, d);
        poly = AS_A5;
        poly = AS_A4 + mulq(t, poly);
        poly = AS_A3 + mulq(t, poly);
        poly = AS_A2 + mulq(t, poly);
        poly = AS_A1 + mulq(t, poly);
        poly = mulq(t, poly);
        h    = ONE_Q - mulq(poly, exp_neg((a * a) / ONE_Q / 2)) / 2;
        if (h < 0)
            h = 0;
        if (h > ONE_Q)
            h = ONE_Q;
        return h;
    endfunction

    // One point of the gain table, evaluated at elaboration.
    function automatic logic [ENTRY_W-1:0] rom_entry(int k, int entries, int frac_bits,
                                                     logic sel_tanh);
        longint num;
        longint xq;
        longint a;
        longint h;
        num = longint'(k) * 65536 - longint'(32768) * longint'(entries);
        xq  = div_trunc(num * (longint'(1) <<< (GQ - frac_bits)), longint'(entries));
        a   = (xq < 0) ? -xq : xq;
        h   = sel_tanh ? g_tanh(a) : g_erf(a);
        if (xq < 0)
            h = ONE_Q - h;
        return ENTRY_W'(h);
    endfunction

endpackage

FILE: design/gelu_rom.sv
module gelu_rom
    import gelu_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF,
    localparam int AW           = $clog2(TABLE_ENTRIES + 1)
)
(
    input  logic               mode,
    input  logic [AW-1:0]      addr_lo,
    input  logic [AW-1:0]      addr_hi,
    output logic [ENTRY_W-1:0] entry_lo,
    output logic [ENTRY_W-1:0] entry_hi
);

    logic [ENTRY_W-1:0] erf_tab  [TABLE_ENTRIES+1];
    logic [ENTRY_W-1:0] tanh_tab [TABLE_ENTRIES+1];

    for (genvar k = 0; k <= TABLE_ENTRIES; k++)
    begin : g_entry
        localparam logic [ENTRY_W-1:0] ERF_V  = rom_entry(k, TABLE_ENTRIES, FRAC_BITS, 1'b0);
        localparam logic [ENTRY_W-1:0] TANH_V = rom_entry(k, TABLE_ENTRIES, FRAC_BITS, 1'b1);
        assign erf_tab[k]  = ERF_V;
        assign tanh_tab[k] = TANH_V;
    end

    assign entry_lo = mode ? tanh_tab[addr_lo] : erf_tab[addr_lo];
    assign entry_hi = mode ? tanh_tab[addr_hi] : erf_tab[addr_hi];

endmodule

FILE: design/gelu_activation_unit.sv
// An input transfer loads the table-read stage; the sample then moves through the product,
// sum and scaling stages to the rounding stage, the output register, unless a stall holds it.
// Throughput: one sample per cycle; five register stages (table read, two interpolation
// products, their sum, scaling by |x|, rounding) each move forward whenever the stage
// after them is empty or moving.
// Reset (rst_n low, asynchronous) clears all valid bits and sets mode to the erf form.
module gelu_activation_unit
    import gelu_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [X_W-1:0] x_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [X_W-1:0] y_out
);

    localparam int AW     = $clog2(TABLE_ENTRIES + 1);
    localparam int IW     = $clog2(TABLE_ENTRIES);
    localparam int FW     = 16;
    localparam int PW     = FW + IW;
    localparam int PA_W   = ENTRY_W + FW + 1;
    localparam int PB_W   = ENTRY_W + FW;
    localparam int PROD_W = ENTRY_W + X_W;

    logic mode_reg;

    logic s0_vld_reg, s1_vld_reg, s2_vld_reg, s3_vld_reg, out_vld_reg;
    logic ld0, ld1, ld2, ld3, ld4;

    logic [X_W-1:0]     u;
    logic [PW-1:0]      p;
    logic [AW-1:0]      addr_lo, addr_hi;
    logic [ENTRY_W-1:0] entry_lo, entry_hi;
    logic [X_W-1:0]     mag_next;

    logic [ENTRY_W-1:0] s0_t0_reg, s0_t1_reg;
    logic [FW-1:0]      s0_frac_reg;
    logic [X_W-1:0]     s0_mag_reg;
    logic               s0_neg_reg;

    logic [PA_W-1:0]    pa_next;
    logic [PB_W-1:0]    pb_next;
    logic [PA_W-1:0]    s1_pa_reg;
    logic [PB_W-1:0]    s1_pb_reg;
    logic [X_W-1:0]     s1_mag_reg;
    logic               s1_neg_reg;

    logic [PA_W-1:0]    sum_next;
    logic [ENTRY_W-1:0] s2_g_reg;
    logic [X_W-1:0]     s2_mag_reg;
    logic               s2_neg_reg;

    logic [PROD_W-1:0]  prod_next;
    logic [PROD_W-1:0]  s3_prod_reg;
    logic               s3_neg_reg;

    logic [PROD_W-1:0]  rnd;
    logic [X_W-1:0]     r;
    logic [X_W-1:0]     y_next;
    logic [X_W-1:0]     y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cfg_wr_en)
            mode_reg <= cfg_wr_data;
    end

    assign ld4      = !out_vld_reg || out_ready;
    assign ld3      = !s3_vld_reg || ld4;
    assign ld2      = !s2_vld_reg || ld3;
    assign ld1      = !s1_vld_reg || ld2;
    assign ld0      = !s0_vld_reg || ld1;
    assign in_ready = ld0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (ld0)
                s0_vld_reg <= in_valid;
            if (ld1)
                s1_vld_reg <= s0_vld_reg;
            if (ld2)
                s2_vld_reg <= s1_vld_reg;
            if (ld3)
                s3_vld_reg <= s2_vld_reg;
            if (ld4)
                out_vld_reg <= s3_vld_reg;
        end
    end

    // The offset code spans the table evenly; its scaled top bits pick the segment.
    assign u        = {~x_in[X_W-1], x_in[X_W-2:0]};
    assign p        = PW'(u) * PW'(TABLE_ENTRIES);
    assign addr_lo  = AW'(p[PW-1:FW]);
    assign addr_hi  = AW'(p[PW-1:FW]) + AW'(1);
    assign mag_next = x_in[X_W-1] ? X_W'(-x_in) : X_W'(x_in);

    gelu_rom #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .FRAC_BITS     (FRAC_BITS)
    ) u_rom (
        .mode     (mode_reg),
        .addr_lo  (addr_lo),
        .addr_hi  (addr_hi),
        .entry_lo (entry_lo),
        .entry_hi (entry_hi)
    );

    always_ff @(posedge clk)
    begin
        if (ld0)
        begin
            s0_t0_reg   <= entry_lo;
            s0_t1_reg   <= entry_hi;
            s0_frac_reg <= p[FW-1:0];
            s0_mag_reg  <= mag_next;
            s0_neg_reg  <= x_in[X_W-1];
        end
    end

    assign pa_next = PA_W'(s0_t0_reg) * (PA_W'(1) << FW) - PA_W'(s0_t0_reg) * PA_W'(s0_frac_reg);
    assign pb_next = PB_W'(s0_t1_reg) * PB_W'(s0_frac_reg);

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            s1_pa_reg  <= pa_next;
            s1_pb_reg  <= pb_next;
            s1_mag_reg <= s0_mag_reg;
            s1_neg_reg <= s0_neg_reg;
        end
    end

    assign sum_next = s1_pa_reg + PA_W'(s1_pb_reg) + (PA_W'(1) << (FW - 1));

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            s2_g_reg   <= sum_next[FW +: ENTRY_W];
            s2_mag_reg <= s1_mag_reg;
            s2_neg_reg <= s1_neg_reg;
        end
    end

    assign prod_next = PROD_W'(s2_mag_reg) * PROD_W'(s2_g_reg);

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            s3_prod_reg <= prod_next;
            s3_neg_reg  <= s2_neg_reg;
        end
    end

    assign rnd    = s3_prod_reg + (PROD_W'(1) << (GQ - 1));
    assign r      = rnd[GQ +: X_W];
    assign y_next = s3_neg_reg ? X_W'(-r) : r;

    always_ff @(posedge clk)
    begin
        if (ld4)
            y_reg <= y_next;
    end

    assign out_valid = out_vld_reg;
    assign y_out     = signed'(y_reg);

endmodule

FILE: design/gelu_chk.sv
`include "gelu_activation_unit_assert.svh"

module gelu_chk
    import gelu_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic signed [X_W-1:0] x_in,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic signed [X_W-1:0] y_out
);

    // A result waiting for a transfer must hold still.
    `GELU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(y_out))

    // With the output register empty, the whole pipeline can move.
    `GELU_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)

    // Without back pressure a sample appears at the output once it has passed through every stage.
    `GELU_ASSERT_NEXT(a_latency, in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready, out_valid)

    // Zero maps to zero and a non-negative sample never gives a negative result.
    `GELU_ASSERT_NEXT(a_sign, in_valid && in_ready && !x_in[X_W-1] && out_ready ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready, !y_out[X_W-1])

    `GELU_ASSERT_NEXT(a_zero, in_valid && in_ready && x_in == '0 && out_ready ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready, y_out == '0)

endmodule

bind gelu_activation_unit gelu_chk u_gelu_chk (.*);
